FILE: rtl/grbd_pkg.sv
// ----------------------------------------------------------------------------
// grbd_pkg: shared types and constants of the Golomb-Rice block decoder
// Field widths, header sizes, magnitude limits and the item type passed
// from the input stage to the decode core.
// ----------------------------------------------------------------------------
package grbd_pkg;

   localparam int PARAM_BITS       = 5;
   localparam int MAG_BITS         = 16;
   localparam int COUNT_WIDTH_BITS = 6;
   localparam int COUNT_BITS       = 32;
   localparam int INDEX_BITS       = 6;
   localparam int QUOT_BITS        = 17;
   localparam int VALUE_BITS       = 17;
   localparam int FIELD_MAG_BITS   = 16;
   localparam int REM_BITS         = (1 << PARAM_BITS) - 1;
   localparam int SHIFT_BITS       = QUOT_BITS + REM_BITS;
   localparam int REQ_DATA_BITS    = 8;
   localparam int RSP_DATA_BITS    = 24;

   localparam logic [COUNT_WIDTH_BITS-1:0] COUNT_WIDTH_RESET = COUNT_WIDTH_BITS'(16);
   localparam logic [QUOT_BITS-1:0]        QUOT_MAX          = '1;
   localparam logic [FIELD_MAG_BITS-1:0]   MAG_LIMIT         =
      (MAG_BITS >= FIELD_MAG_BITS) ? '1 : FIELD_MAG_BITS'((64'd1 << MAG_BITS) - 64'd1);

   typedef struct packed {
      logic valid;
      logic code_bit;
   } grbd_item_type;

endpackage

FILE: rtl/grbd_in_stage.sv
// ----------------------------------------------------------------------------
// grbd_in_stage: input register of the decoder
// Captures one code bit per cycle and holds it until the core takes it.
// ----------------------------------------------------------------------------
module grbd_in_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [grbd_pkg::REQ_DATA_BITS-1:0] req_tdata,  // [0] code_bit
   input  logic                               core_ready,
   output grbd_pkg::grbd_item_type            item
);
   import grbd_pkg::*;

   logic valid_ff;
   logic valid_in;
   logic bit_ff;
   logic bit_in;

   assign req_tready = !valid_ff || core_ready;

   always_comb begin
      valid_in = valid_ff;
      bit_in   = bit_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
         bit_in   = req_tdata[0];
      end else if (core_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      bit_ff <= bit_in;
   end

   assign item.valid    = valid_ff;
   assign item.code_bit = bit_ff;

endmodule

FILE: rtl/grbd_core.sv
// ----------------------------------------------------------------------------
// grbd_core: header, sign, unary and remainder decode with result register
// Updates the parse state for one code bit per cycle unless a held result is
// stalled on rsp, and registers each completed symbol.
// ----------------------------------------------------------------------------
module grbd_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [grbd_pkg::COUNT_WIDTH_BITS-1:0] csr_wdata,
   input  grbd_pkg::grbd_item_type               item,
   output logic                                  core_ready,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [grbd_pkg::VALUE_BITS-1:0]       symbol_value,
   output logic                                  overflow,
   output logic                                  block_last
);
   import grbd_pkg::*;

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_PARAM,
      PH_SIGN,
      PH_UNARY,
      PH_REM
   } phase_type;

   logic [COUNT_WIDTH_BITS-1:0] count_width_ff;
   phase_type                   phase_ff, phase_in;
   logic [INDEX_BITS-1:0]       bit_index_ff, bit_index_in;
   logic [COUNT_BITS-1:0]       symbols_left_ff, symbols_left_in;
   logic [PARAM_BITS-1:0]       rice_param_ff, rice_param_in;
   logic                        sign_ff, sign_in;
   logic [QUOT_BITS-1:0]        quotient_ff, quotient_in;
   logic [REM_BITS-1:0]         remainder_ff, remainder_in;
   logic                        ovf_held_ff, ovf_held_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]       value_ff, value_in;
   logic                        ovf_ff, ovf_in;
   logic                        last_ff, last_in;

   logic                        take;
   logic                        emit;
   logic                        b;
   phase_type                   phase_eff;
   logic [INDEX_BITS-1:0]       index_eff;
   logic [COUNT_BITS-1:0]       left_eff;
   logic [PARAM_BITS-1:0]       param_eff;
   logic [INDEX_BITS:0]         index_inc;
   logic [REM_BITS-1:0]         rem_next;
   logic [SHIFT_BITS-1:0]       mag_full;
   logic                        mag_big;
   logic [FIELD_MAG_BITS-1:0]   mag_sat;
   logic                        ovf_sym;
   logic [COUNT_BITS-1:0]       left_dec;
   logic [7:0]                  param_bit;

   assign core_ready = !rsp_valid_ff || rsp_tready;
   assign take       = item.valid && core_ready;
   assign b          = item.code_bit;

   // Symbol magnitude: quotient and remainder do not overlap, so OR is the sum
   assign rem_next = remainder_ff | (REM_BITS'(b) << bit_index_ff[PARAM_BITS-1:0]);
   assign mag_full = (SHIFT_BITS'(quotient_ff) << rice_param_ff)
                   | SHIFT_BITS'(phase_ff == PH_REM ? rem_next : '0);
   assign mag_big  = (|mag_full[SHIFT_BITS-1:FIELD_MAG_BITS])
                   || (mag_full[FIELD_MAG_BITS-1:0] > MAG_LIMIT);
   assign mag_sat  = mag_big ? MAG_LIMIT : mag_full[FIELD_MAG_BITS-1:0];
   assign ovf_sym  = ovf_held_ff || mag_big;
   assign left_dec = symbols_left_ff - COUNT_BITS'(1);

   always_comb begin
      phase_eff = phase_ff;
      index_eff = bit_index_ff;
      left_eff  = symbols_left_ff;
      param_eff = rice_param_ff;
      if (phase_ff == PH_COUNT && count_width_ff == '0) begin
         phase_eff = PH_PARAM;
         index_eff = '0;
         left_eff  = '0;
         param_eff = '0;
      end
      index_inc = {1'b0, index_eff} + (INDEX_BITS+1)'(1);
      param_bit = 8'(b) << index_eff[2:0];

      phase_in        = phase_eff;
      bit_index_in    = index_eff;
      symbols_left_in = left_eff;
      rice_param_in   = param_eff;
      sign_in         = sign_ff;
      quotient_in     = quotient_ff;
      remainder_in    = remainder_ff;
      ovf_held_in     = ovf_held_ff;
      emit            = 1'b0;

      case (phase_eff)
         PH_COUNT: begin
            symbols_left_in = (index_eff == '0) ? '0 : left_eff;
            if (!index_eff[INDEX_BITS-1]) begin
               symbols_left_in[index_eff[4:0]] = symbols_left_in[index_eff[4:0]] | b;
            end
            if (index_inc >= {1'b0, count_width_ff}) begin
               phase_in      = PH_PARAM;
               bit_index_in  = '0;
               rice_param_in = '0;
            end else begin
               bit_index_in = index_inc[INDEX_BITS-1:0];
            end
         end
         PH_PARAM: begin
            rice_param_in = ((index_eff == '0) ? '0 : param_eff) | param_bit[PARAM_BITS-1:0];
            bit_index_in  = index_inc[INDEX_BITS-1:0];
            if (index_inc >= (INDEX_BITS+1)'(PARAM_BITS)) begin
               bit_index_in = '0;
               phase_in     = (left_eff == '0) ? PH_COUNT : PH_SIGN;
            end
         end
         PH_SIGN: begin
            sign_in      = b;
            quotient_in  = '0;
            remainder_in = '0;
            ovf_held_in  = 1'b0;
            phase_in     = PH_UNARY;
         end
         PH_UNARY: begin
            if (!b) begin
               if (quotient_ff < QUOT_MAX) begin
                  quotient_in = quotient_ff + QUOT_BITS'(1);
               end else begin
                  ovf_held_in = 1'b1;
               end
            end else begin
               remainder_in = '0;
               bit_index_in = '0;
               if (rice_param_ff == '0) begin
                  emit = 1'b1;
               end else begin
                  phase_in = PH_REM;
               end
            end
         end
         PH_REM: begin
            remainder_in = rem_next;
            bit_index_in = index_inc[INDEX_BITS-1:0];
            if (index_inc >= (INDEX_BITS+1)'(rice_param_ff)) begin
               emit = 1'b1;
            end
         end
         default: begin
            phase_in     = PH_COUNT;
            bit_index_in = '0;
         end
      endcase

      if (emit) begin
         symbols_left_in = left_dec;
         phase_in        = (left_dec == '0) ? PH_COUNT : PH_SIGN;
         bit_index_in    = '0;
      end

      value_in = value_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (take && emit) begin
         rsp_valid_in = 1'b1;
         value_in     = (sign_ff && mag_sat != '0) ? -VALUE_BITS'(mag_sat)
                                                  : VALUE_BITS'(mag_sat);
         ovf_in       = ovf_sym;
         last_in      = (symbols_left_ff == COUNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_width_ff  <= COUNT_WIDTH_RESET;
         phase_ff        <= PH_COUNT;
         bit_index_ff    <= '0;
         symbols_left_ff <= '0;
         rice_param_ff   <= '0;
         sign_ff         <= 1'b0;
         quotient_ff     <= '0;
         remainder_ff    <= '0;
         ovf_held_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            count_width_ff <= csr_wdata;
         end
         if (take) begin
            phase_ff        <= phase_in;
            bit_index_ff    <= bit_index_in;
            symbols_left_ff <= symbols_left_in;
            rice_param_ff   <= rice_param_in;
            sign_ff         <= sign_in;
            quotient_ff     <= quotient_in;
            remainder_ff    <= remainder_in;
            ovf_held_ff     <= ovf_held_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff <= value_in;
      ovf_ff   <= ovf_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign symbol_value = value_ff;
   assign overflow     = ovf_ff;
   assign block_last   = last_ff;

endmodule

FILE: rtl/golomb_rice_block_decoder.sv
// ----------------------------------------------------------------------------
// golomb_rice_block_decoder: bit-serial Golomb-Rice block decoder
//
// The req channel takes one code bit per item in req_tdata[0]. Each block of
// the stream is a count header (csr-set width, LSB first), a 5-bit Rice
// parameter, then that many symbols of sign, unary quotient and remainder.
// The rsp channel returns one item per decoded symbol: the signed value in
// rsp_tdata, the saturation flag in rsp_tuser and the final symbol of a block
// on rsp_tlast. Only the bit that completes a symbol gives an rsp item.
// The csr port writes the count header width; write it only while idle.
// Throughput is one code bit per cycle while rsp does not stall. A symbol is
// presented on rsp once the item that completes it has passed the input
// register and the decode logic has filled the result register.
// Reset clears the input and result registers and returns the parser to
// reading a count header, with a header width of 16.
// When rsp stalls with a result held, decoding pauses and req_tready drops
// once the input register is also full; no item is lost.
// ----------------------------------------------------------------------------
module golomb_rice_block_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [grbd_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // [0] code_bit
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [grbd_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // [16:0] symbol_value
   output logic                                  rsp_tuser,  // [0] overflow
   output logic                                  rsp_tlast,
   input  logic                                  csr_we,
   input  logic [grbd_pkg::COUNT_WIDTH_BITS-1:0] csr_wdata
);
   import grbd_pkg::*;

   grbd_item_type         item;
   logic                  core_ready;
   logic [VALUE_BITS-1:0] symbol_value;

   grbd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .core_ready (core_ready),
      .item       (item)
   );

   grbd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .item         (item),
      .core_ready   (core_ready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .symbol_value (symbol_value),
      .overflow     (rsp_tuser),
      .block_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS-VALUE_BITS){1'b0}}, symbol_value};

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for golomb_rice_block_decoder
// Feeds code bits one item at a time and predicts every decoded symbol with
// an in-bench bit-serial parser. The bench starts with short directed blocks:
// zero and negative-zero symbols, a zero-count block, an empty count header
// and a count-width change in the middle of a header. The random part is
// mostly well-formed blocks with random content under many header widths,
// plus truncated blocks and noise that are then walked back to a block
// boundary.
// Both sides idle and stall at random; symbols are checked field by field
// in order.
// ----------------------------------------------------------------------------
module tb;
   import grbd_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TOTAL_ITEMS   = 1250;
   localparam int PHASE_ITEMS   = 160;

   typedef enum logic [2:0] {ST_COUNT, ST_PARAM, ST_SIGN, ST_UNARY, ST_REM} parse_state_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  overflow;
      logic                  last;
   } symbol_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_DATA_BITS-1:0]    req_tdata = '0;      // [0] code_bit
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]    rsp_tdata;           // [16:0] symbol_value
   logic                        rsp_tuser;           // [0] overflow
   logic                        rsp_tlast;
   logic                        csr_we = 1'b0;
   logic [COUNT_WIDTH_BITS-1:0] csr_wdata = '0;

   golomb_rice_block_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // bit-serial parser state
   parse_state_type             dec_phase;
   int unsigned                 dec_idx;
   logic [COUNT_BITS-1:0]       dec_left;
   logic [PARAM_BITS-1:0]       dec_param;
   logic                        dec_sign;
   logic [QUOT_BITS-1:0]        dec_quot;
   logic [31:0]                 dec_rem;
   logic                        dec_ovf;
   logic [COUNT_WIDTH_BITS-1:0] cur_width = COUNT_WIDTH_RESET;

   logic       pending_bits[$];
   symbol_type expected_symbols[$];

   bit send_steady = 1'b0;
   bit rsp_steady  = 1'b0;
   int send_wait = 0;
   int hold_wait = 0;
   int gen_width = 16;
   int bits_queued = 0;
   int bits_decoded = 0;
   int symbols_checked = 0;
   int saturated_seen = 0;
   int block_ends = 0;
   int widths_used = 0;
   int failures = 0;
   int cycle_count = 0;
   int width_plan [12] = '{1, 32, 63, 4, 16, 2, 33, 8, 5, 24, 3, 12};

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int draw_wait(input bit steady);
      if (steady || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 11);
   endfunction

   function automatic void clear_decoder();
      dec_phase = ST_COUNT;
      dec_idx   = 0;
      dec_left  = '0;
      dec_param = '0;
      dec_sign  = 1'b0;
      dec_quot  = '0;
      dec_rem   = '0;
      dec_ovf   = 1'b0;
      cur_width = COUNT_WIDTH_RESET;
   endfunction

   function automatic void finish_symbol();
      logic [63:0] mag;
      logic [63:0] neg;
      symbol_type  s;
      mag = ({47'd0, dec_quot} << dec_param) + {32'd0, dec_rem};
      s.overflow = dec_ovf;
      if (mag > {48'd0, MAG_LIMIT}) begin
         mag = {48'd0, MAG_LIMIT};
         s.overflow = 1'b1;
      end
      neg = 64'd0 - mag;
      s.value = (dec_sign && mag != 0) ? neg[VALUE_BITS-1:0] : mag[VALUE_BITS-1:0];
      s.last = (dec_left == 1);
      dec_left = dec_left - 1;
      dec_phase = (dec_left == 0) ? ST_COUNT : ST_SIGN;
      dec_idx = 0;
      expected_symbols = {expected_symbols, s};
   endfunction

   function automatic void decode_bit(input logic b);
      if (dec_phase == ST_COUNT && cur_width == 0) begin
         dec_left  = '0;
         dec_phase = ST_PARAM;
         dec_idx   = 0;
         dec_param = '0;
      end
      case (dec_phase)
         ST_COUNT: begin
            if (dec_idx == 0)
               dec_left = '0;
            if (dec_idx < COUNT_BITS)
               dec_left = dec_left | ({31'd0, b} << dec_idx);
            if (dec_idx + 1 >= cur_width) begin
               dec_phase = ST_PARAM;
               dec_idx   = 0;
               dec_param = '0;
            end else begin
               dec_idx = (dec_idx + 1) % 64;
            end
         end
         ST_PARAM: begin
            if (dec_idx == 0)
               dec_param = '0;
            dec_param = dec_param | ({4'd0, b} << dec_idx);
            dec_idx++;
            if (dec_idx >= PARAM_BITS) begin
               dec_idx = 0;
               dec_phase = (dec_left == 0) ? ST_COUNT : ST_SIGN;
            end
         end
         ST_SIGN: begin
            dec_sign  = b;
            dec_quot  = '0;
            dec_rem   = '0;
            dec_ovf   = 1'b0;
            dec_phase = ST_UNARY;
         end
         ST_UNARY: begin
            if (!b) begin
               if (dec_quot != QUOT_MAX)
                  dec_quot++;
               else
                  dec_ovf = 1'b1;
            end else begin
               dec_rem = '0;
               dec_idx = 0;
               if (dec_param == 0)
                  finish_symbol();
               else
                  dec_phase = ST_REM;
            end
         end
         ST_REM: begin
            dec_rem = dec_rem | ({31'd0, b} << dec_idx);
            dec_idx++;
            if (dec_idx >= dec_param)
               finish_symbol();
         end
         default: begin
            dec_phase = ST_COUNT;
            dec_idx = 0;
         end
      endcase
   endfunction

   always @(posedge clock) begin : req_driver
      logic [REQ_DATA_BITS-1:0] word;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = 0;
         clear_decoder();
      end else begin
         if (req_tvalid && req_tready) begin
            decode_bit(req_tdata[0]);
            bits_decoded++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (pending_bits.size() != 0) begin
               word = '0;
               word[0] = pending_bits.pop_front();
               req_tdata <= word;
               req_tvalid <= 1'b1;
               send_wait = draw_wait(send_steady);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      symbol_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_symbols.size() == 0) begin
               $error("unexpected symbol_value %0d", $signed(rsp_tdata[VALUE_BITS-1:0]));
               failures++;
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_tdata[VALUE_BITS-1:0] !== want.value) begin
                  $error("symbol_value: expected %0d, got %0d", $signed(want.value),
                         $signed(rsp_tdata[VALUE_BITS-1:0]));
                  failures++;
               end
               if (rsp_tuser !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_tuser);
                  failures++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("block_last: expected %0b, got %0b", want.last, rsp_tlast);
                  failures++;
               end
            end
            symbols_checked++;
            if (rsp_tuser)
               saturated_seen++;
            if (rsp_tlast)
               block_ends++;
            hold_wait = draw_wait(rsp_steady);
         end else if (hold_wait > 0) begin
            hold_wait--;
         end
         rsp_tready <= (hold_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("golomb_rice_block_decoder test failed");
         $finish;
      end
   end

   task automatic queue_bit(input logic b);
      pending_bits = {pending_bits, b};
      bits_queued++;
   endtask

   task automatic queue_bits(input logic [63:0] v, input int n);
      for (int i = 0; i < n; i++)
         queue_bit(v[i]);
   endtask

   task automatic queue_header(input logic [31:0] count, input logic [PARAM_BITS-1:0] p);
      for (int i = 0; i < gen_width; i++) begin
         if (i < COUNT_BITS)
            queue_bit(count[i]);
         else
            queue_bit(1'($urandom_range(0, 1)));
      end
      queue_bits({59'd0, p}, PARAM_BITS);
   endtask

   task automatic queue_symbol(input logic neg, input int quot, input logic [31:0] rem,
                               input int p);
      queue_bit(neg);
      repeat (quot) queue_bit(1'b0);
      queue_bit(1'b1);
      queue_bits({32'd0, rem}, p);
   endtask

   task automatic queue_random_symbol(input int p);
      int quot;
      quot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
      queue_symbol(1'($urandom_range(0, 1)), quot, $urandom, p);
   endtask

   task automatic pick_block(output int count, output int p);
      int limit;
      limit = (gen_width >= 4) ? 8 : ((1 << gen_width) - 1);
      count = ($urandom_range(0, 11) == 0 || limit == 0) ? 0 : $urandom_range(1, limit);
      case ($urandom_range(0, 9))
         0:       p = $urandom_range(17, 31);
         1, 2:    p = $urandom_range(9, 16);
         default: p = $urandom_range(0, 8);
      endcase
   endtask

   task automatic queue_random_block();
      int count;
      int p;
      pick_block(count, p);
      queue_header(count, p[PARAM_BITS-1:0]);
      repeat (count) queue_random_symbol(p);
   endtask

   task automatic drain_sender();
      do begin
         @(negedge clock);
      end while (pending_bits.size() != 0 || req_tvalid);
   endtask

   // feed filler bits until the parser sits at the start of a count header
   task automatic realign();
      drain_sender();
      while (!(dec_phase == ST_COUNT && dec_idx == 0)) begin
         queue_bit((dec_phase == ST_COUNT || dec_phase == ST_PARAM) ? 1'b0 : 1'b1);
         drain_sender();
      end
   endtask

   task automatic queue_broken_block();
      int count;
      int p;
      pick_block(count, p);
      if (count == 0)
         count = 1;
      queue_header(count, p[PARAM_BITS-1:0]);
      repeat ($urandom_range(0, count - 1)) queue_random_symbol(p);
      repeat ($urandom_range(1, 24)) queue_bit(1'($urandom_range(0, 1)));
      realign();
   endtask

   task automatic wait_idle();
      drain_sender();
      while (expected_symbols.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input int w);
      logic [31:0] wv;
      wait_idle();
      wv = w;
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= wv[COUNT_WIDTH_BITS-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      cur_width = wv[COUNT_WIDTH_BITS-1:0];
      gen_width = w;
      widths_used++;
   endtask

   initial begin : stimulus
      int phase_start;
      int round;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero, negative zero, then -2 closing the block; then a zero-count block
      write_width(2);
      queue_header(3, 0);
      queue_symbol(1'b0, 0, 0, 0);
      queue_symbol(1'b1, 0, 0, 0);
      queue_symbol(1'b1, 2, 0, 0);
      queue_header(0, 5'd21);

      // empty count header: parameter only
      write_width(0);
      queue_header(0, 5'd10);

      // change the width after five count bits have gone in
      write_width(16);
      queue_bits(64'b00011, 5);
      write_width(2);
      queue_bit(1'b0);
      queue_bits(64'd1, PARAM_BITS);
      queue_symbol(1'b0, 0, 1, 1);
      queue_symbol(1'b1, 3, 0, 1);
      queue_symbol(1'b1, 1, 1, 1);

      round = 0;
      while (bits_queued < TOTAL_ITEMS) begin
         write_width(width_plan[round % 12]);
         send_steady = (round % 3 == 2);
         rsp_steady = (round % 4 == 1);
         phase_start = bits_queued;
         while (bits_queued - phase_start < PHASE_ITEMS && bits_queued < TOTAL_ITEMS) begin
            if (gen_width >= 1 && gen_width <= 5 && $urandom_range(0, 9) == 0)
               queue_broken_block();
            else
               queue_random_block();
         end
         round++;
      end
      wait_idle();

      $display("Checked %0d symbols (%0d saturated, %0d block ends) from %0d code bits",
               symbols_checked, saturated_seen, block_ends, bits_decoded);
      $display("Used %0d count-width writes, including an empty header and a mid-header change",
               widths_used);
      if (failures == 0)
         $display("golomb_rice_block_decoder test passed");
      else
         $display("golomb_rice_block_decoder test failed");
      $finish;
   end

endmodule
